[rtl/awls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awls_pkg
// shared types and constants of the audio window level meter
// ----------------------------------------------------------------------------
package awls_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = 40;
    localparam int SQ_W      = 63;
    localparam int SQ_DIV_W  = 64;
    localparam int CNT_W     = 17;
    localparam int ROOT_ITER = 32;

    localparam logic [1:0] KIND_FINITE = 2'd0;
    localparam logic [1:0] KIND_NAN    = 2'd1;

    localparam logic [SAMPLE_W-1:0] ONE_Q20 = 24'd1048576;

    typedef struct packed {
        logic acc_step;
        logic start_div;
        logic div_step;
        logic start_root;
        logic root_step;
        logic load_out;
    } awls_cmd_t;

    typedef struct packed {
        logic div_done;
        logic root_done;
    } awls_stat_t;

endpackage

[rtl/awls_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awls_in_if / awls_out_if
// valid-ready channels carrying one beat each
// ----------------------------------------------------------------------------
interface awls_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] sample;
    logic [1:0]  sample_kind;
    logic        last_sample;
    modport source (output valid, sample, sample_kind, last_sample, input ready);
    modport sink   (input valid, sample, sample_kind, last_sample, output ready);
endinterface

interface awls_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] peak_level;
    logic [23:0] dc_offset;
    logic [23:0] rms_level;
    logic [16:0] clipped_count;
    logic        saw_nan;
    logic        saw_infinite;
    logic        window_overflow;
    modport source (output valid, peak_level, dc_offset, rms_level, clipped_count,
                    saw_nan, saw_infinite, window_overflow, input ready);
    modport sink   (input valid, peak_level, dc_offset, rms_level, clipped_count,
                    saw_nan, saw_infinite, window_overflow, output ready);
endinterface

[rtl/awls_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awls_ctrl
// sequencer: accumulate, divide, root, hand result to output register
// ----------------------------------------------------------------------------
module awls_ctrl
    import awls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    input  logic       out_busy,
    input  awls_stat_t stat,
    output awls_cmd_t  cmd
);

    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [2:0] ST_PREP = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACC;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                in_ready     = 1'b1;
                cmd.acc_step = in_valid;
                if (in_valid && in_last)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.start_div = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_step   = 1'b0;
                    cmd.start_root = 1'b1;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_done)
                begin
                    cmd.root_step = 1'b0;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    a_step_only_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_step |-> state_reg == ST_ACC) else $error("acc outside acc");
    a_load_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> state_reg == ST_ACC) else $error("bad return");
    a_div_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_root |=> state_reg == ST_ROOT) else $error("bad root start");

endmodule

[rtl/awls_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awls_dp
// accumulators, restoring divider and digit-by-digit square root
// ----------------------------------------------------------------------------
module awls_dp
    import awls_pkg::*;
#(
    parameter int MAX_WINDOW = 65536
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  awls_cmd_t           cmd,
    output awls_stat_t          stat,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [1:0]          sample_kind,
    output logic [SAMPLE_W-1:0] peak_val,
    output logic [SAMPLE_W-1:0] dc_val,
    output logic [SAMPLE_W-1:0] rms_val,
    output logic [CNT_W-1:0]    clip_val,
    output logic                nan_val,
    output logic                inf_val,
    output logic                ovf_val
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOW);

    logic [SAMPLE_W-1:0] peak_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [CNT_W-1:0]    clip_reg;
    logic [CNT_W-1:0]    total_reg;
    logic                nan_reg, inf_reg, ovf_reg;

    logic signed [SAMPLE_W:0] s_ext;
    logic [SAMPLE_W-1:0]      mag;
    logic [2*SAMPLE_W-1:0]    mag_sq;

    assign s_ext  = {sample[SAMPLE_W-1], sample};
    assign mag    = sample[SAMPLE_W-1] ? SAMPLE_W'(-s_ext) : sample;
    assign mag_sq = mag * mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            clip_reg  <= '0;
            total_reg <= '0;
            nan_reg   <= 1'b0;
            inf_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            peak_reg  <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            clip_reg  <= '0;
            total_reg <= '0;
            nan_reg   <= 1'b0;
            inf_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.acc_step)
        begin
            if (total_reg >= MAX_CNT)
                ovf_reg <= 1'b1;
            else
            begin
                total_reg <= total_reg + 1'b1;
                if (sample_kind == KIND_NAN)
                    nan_reg <= 1'b1;
                else if (sample_kind != KIND_FINITE)
                    inf_reg <= 1'b1;
                else
                begin
                    if (mag > peak_reg)
                        peak_reg <= mag;
                    if (mag > ONE_Q20)
                        clip_reg <= clip_reg + 1'b1;
                    sum_reg <= sum_reg + SUM_W'(signed'(s_ext));
                    sq_reg  <= sq_reg + SQ_W'(mag_sq);
                end
            end
        end
    end

    // restoring dividers for |sum| and sumsq by total, sharing one step counter, one bit per cycle
    logic [SQ_DIV_W-1:0] sq_q_reg;
    logic [CNT_W:0]      sq_r_reg;
    logic [SUM_W-1:0]    sm_q_reg;
    logic [CNT_W:0]      sm_r_reg;
    logic                sm_neg_reg;
    logic [6:0]          div_cnt_reg;
    logic [CNT_W+1:0]    sq_try, sm_try;
    logic [CNT_W+1:0]    sq_sh, sm_sh;
    logic [SUM_W-1:0]    sum_abs;

    assign sum_abs = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign sq_sh   = {sq_r_reg, sq_q_reg[SQ_DIV_W-1]};
    assign sm_sh   = {sm_r_reg, sm_q_reg[SUM_W-1]};
    assign sq_try  = sq_sh - {1'b0, total_reg};
    assign sm_try  = sm_sh - {1'b0, total_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            sq_q_reg    <= {1'b0, sq_reg};
            sq_r_reg    <= '0;
            sm_q_reg    <= sum_abs;
            sm_r_reg    <= '0;
            sm_neg_reg  <= sum_reg[SUM_W-1];
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (!sq_try[CNT_W+1])
                {sq_r_reg, sq_q_reg} <= {sq_try[CNT_W:0], sq_q_reg[SQ_DIV_W-2:0], 1'b1};
            else
                {sq_r_reg, sq_q_reg} <= {sq_sh[CNT_W:0], sq_q_reg[SQ_DIV_W-2:0], 1'b0};
            if (div_cnt_reg < 7'(SUM_W))
            begin
                if (!sm_try[CNT_W+1])
                    {sm_r_reg, sm_q_reg} <= {sm_try[CNT_W:0], sm_q_reg[SUM_W-2:0], 1'b1};
                else
                    {sm_r_reg, sm_q_reg} <= {sm_sh[CNT_W:0], sm_q_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign stat.div_done = (div_cnt_reg == 7'(SQ_DIV_W));

    // integer square root, two radicand bits per cycle
    logic [SQ_DIV_W-1:0] rad_reg;
    logic [SQ_DIV_W/2+1:0] rem_reg;
    logic [SQ_DIV_W/2-1:0] root_reg;
    logic [5:0]          rt_cnt_reg;
    logic [SQ_DIV_W/2+1:0] rem_sh, rt_try;

    assign rem_sh = {rem_reg[SQ_DIV_W/2-1:0], rad_reg[SQ_DIV_W-1 -: 2]};
    assign rt_try = rem_sh - {root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.start_root)
        begin
            rad_reg    <= sq_q_reg;
            rem_reg    <= '0;
            root_reg   <= '0;
            rt_cnt_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rt_cnt_reg <= rt_cnt_reg + 1'b1;
            rad_reg    <= {rad_reg[SQ_DIV_W-3:0], 2'b00};
            if (rem_sh >= {root_reg, 2'b01})
            begin
                rem_reg  <= rt_try;
                root_reg <= {root_reg[SQ_DIV_W/2-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[SQ_DIV_W/2-2:0], 1'b0};
            end
        end
    end

    assign stat.root_done = (rt_cnt_reg == 6'(ROOT_ITER));

    logic [SUM_W-1:0] dc_full;
    assign dc_full  = sm_neg_reg ? -sm_q_reg : sm_q_reg;
    assign dc_val   = dc_full[SAMPLE_W-1:0];
    assign rms_val  = root_reg[SAMPLE_W-1:0];
    assign peak_val = peak_reg;
    assign clip_val = clip_reg;
    assign nan_val  = nan_reg;
    assign inf_val  = inf_reg;
    assign ovf_val  = ovf_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAX_CNT) else $error("count past window");
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg <= total_reg) else $error("clip past count");
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> total_reg == MAX_CNT) else $error("overflow early");

endmodule

[rtl/audio_window_level_stats_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_window_level_stats_top
// peak, dc offset, rms and clip meter over a window of Q3.20 samples
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a window is open. After the beat
// marked last the block latches the totals, runs a bit-serial divider (sum
// and sum of squares by sample count together) and a square root, then
// loads the output register; input is held off until that load, which
// waits further while an earlier result still sits unread. A result
// waiting in the output register does not stall the next window's
// accumulation, only its end.
module audio_window_level_stats_top
    import awls_pkg::*;
#(
    parameter int MAX_WINDOW = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    awls_in_if.sink    in_ch,
    awls_out_if.source out_ch
);

    awls_cmd_t  cmd;
    awls_stat_t stat;
    logic       out_valid_reg;
    logic [SAMPLE_W-1:0] peak_val, dc_val, rms_val;
    logic [CNT_W-1:0]    clip_val;
    logic                nan_val, inf_val, ovf_val;

    awls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last_sample),
        .in_ready (in_ch.ready),
        .out_busy (out_valid_reg && !out_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    awls_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .sample      (in_ch.sample),
        .sample_kind (in_ch.sample_kind),
        .peak_val    (peak_val),
        .dc_val      (dc_val),
        .rms_val     (rms_val),
        .clip_val    (clip_val),
        .nan_val     (nan_val),
        .inf_val     (inf_val),
        .ovf_val     (ovf_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ch.peak_level      <= peak_val;
            out_ch.dc_offset       <= dc_val;
            out_ch.rms_level       <= rms_val;
            out_ch.clipped_count   <= clip_val;
            out_ch.saw_nan         <= nan_val;
            out_ch.saw_infinite    <= inf_val;
            out_ch.window_overflow <= ovf_val;
        end
    end

    assign out_ch.valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !out_ch.ready)) else $error("result lost");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg) else $error("valid missing");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ch.ready) else $error("input during divide");

endmodule
